### src/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg: shared types and constants for the date add days unit
// Holds the controller states, the controller/datapath command and status
// structs, and the calendar helper functions.
// ----------------------------------------------------------------------------
package dad_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned STEP_W  = 3;

    localparam logic [YEAR_W-1:0]  YEAR_MAX      = 14'd16383;
    localparam logic [YEAR_W-1:0]  CYCLE_YEARS   = 14'd400;
    localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_LAST_DEC  = 5'd31;
    localparam logic [STEP_W-1:0]  REDUCE_LAST   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CLAMP,
        S_WALK,
        S_DONE
    } dad_state_t;

    typedef struct packed {
        logic load;
        logic reduce;
        logic clamp;
        logic walk;
    } dad_cmd_t;

    typedef struct packed {
        logic reduce_last;
        logic walk_done;
    } dad_status_t;

    // Multiples of 400 used to reduce the year by restoring subtraction.
    function automatic logic [YEAR_W-1:0] reduce_sub(input logic [STEP_W-1:0] step);
        logic [YEAR_W-1:0] val;
        begin
            unique case (step)
                3'd0:    val = 14'd12800;
                3'd1:    val = 14'd6400;
                3'd2:    val = 14'd3200;
                3'd3:    val = 14'd1600;
                3'd4:    val = 14'd800;
                default: val = 14'd400;
            endcase
            return val;
        end
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] val;
        begin
            unique case (month)
                4'd2:                      val = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   val = 5'd30;
                default:                   val = 5'd31;
            endcase
            return val;
        end
    endfunction

endpackage

### src/dad_ctrl.sv
// ----------------------------------------------------------------------------
// dad_ctrl: sequencing controller
// Steps the datapath through year reduction, day clamping and the month walk,
// then presents the result for one cycle.
// ----------------------------------------------------------------------------
module dad_ctrl
    import dad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  dad_status_t status,
    output dad_cmd_t    cmd,
    output logic        busy,
    output logic        done
);

    dad_state_t state_reg;
    dad_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (status.reduce_last)
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_REDUCE:
            begin
                cmd.reduce = 1'b1;
            end
            S_CLAMP:
            begin
                cmd.clamp = 1'b1;
            end
            S_WALK:
            begin
                cmd.walk = !status.walk_done;
            end
            S_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### src/dad_datapath.sv
// ----------------------------------------------------------------------------
// dad_datapath: date registers and month step logic
// Holds the running date, the remaining day count and the year modulo 400,
// and performs one reduction step, the day clamp or one month step per command.
// ----------------------------------------------------------------------------
module dad_datapath
    import dad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dad_cmd_t           cmd,
    input  logic [YEAR_W-1:0]  start_year,
    input  logic [MONTH_W-1:0] start_month,
    input  logic [DAY_W-1:0]   start_day,
    input  logic [COUNT_W-1:0] days_to_add,
    output dad_status_t        status,
    output logic [YEAR_W-1:0]  result_year,
    output logic [MONTH_W-1:0] result_month,
    output logic [DAY_W-1:0]   result_day,
    output logic               year_overflow
);

    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [YEAR_W-1:0]  rem_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               ovf_reg;

    logic               leap;
    logic [DAY_W-1:0]   len;
    logic [DAY_W-1:0]   left;
    logic [YEAR_W-1:0]  sub;
    logic               fits;

    // The remainder register holds the year modulo 400 once reduction ends.
    assign leap = ((year_reg[1:0] == 2'b00) && (rem_reg != 14'd0) && (rem_reg != 14'd100)
                   && (rem_reg != 14'd200) && (rem_reg != 14'd300)) || (rem_reg == 14'd0);
    assign len  = month_days(month_reg, leap);
    assign left = len - day_reg;
    assign fits = count_reg <= {{(COUNT_W-DAY_W){1'b0}}, left};
    assign sub  = reduce_sub(step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                step_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            else if (cmd.reduce)
            begin
                step_reg <= step_reg + 3'd1;
            end
            else if (cmd.walk && !fits && (month_reg == MONTH_DEC) && (year_reg == YEAR_MAX))
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            year_reg  <= (start_year == '0) ? 14'd1 : start_year;
            rem_reg   <= (start_year == '0) ? 14'd1 : start_year;
            month_reg <= (start_month == '0) ? MONTH_JAN :
                         ((start_month > MONTH_DEC) ? MONTH_DEC : start_month);
            day_reg   <= (start_day == '0) ? 5'd1 : start_day;
            count_reg <= days_to_add;
        end
        else if (cmd.reduce)
        begin
            if (rem_reg >= sub)
            begin
                rem_reg <= rem_reg - sub;
            end
        end
        else if (cmd.clamp)
        begin
            if (day_reg > len)
            begin
                day_reg <= len;
            end
        end
        else if (cmd.walk)
        begin
            if (fits)
            begin
                day_reg   <= day_reg + count_reg[DAY_W-1:0];
                count_reg <= '0;
            end
            else if (month_reg != MONTH_DEC)
            begin
                count_reg <= count_reg - {{(COUNT_W-DAY_W){1'b0}}, left};
                day_reg   <= '0;
                month_reg <= month_reg + 4'd1;
            end
            else if (year_reg == YEAR_MAX)
            begin
                // The walk ran past the last year; saturate to its last day.
                day_reg   <= DAY_LAST_DEC;
                count_reg <= '0;
            end
            else
            begin
                count_reg <= count_reg - {{(COUNT_W-DAY_W){1'b0}}, left};
                day_reg   <= '0;
                month_reg <= MONTH_JAN;
                year_reg  <= year_reg + 14'd1;
                rem_reg   <= (rem_reg == CYCLE_YEARS - 14'd1) ? 14'd0 : rem_reg + 14'd1;
            end
        end
    end

    assign status.reduce_last = (step_reg == REDUCE_LAST);
    assign status.walk_done   = (count_reg == '0);

    assign result_year   = year_reg;
    assign result_month  = month_reg;
    assign result_day    = day_reg;
    assign year_overflow = ovf_reg;

endmodule

### src/date_add_days_unit.sv
// ----------------------------------------------------------------------------
// date_add_days_unit: Gregorian date plus a count of days
// Sequence: a year reduction modulo 400 by restoring subtraction, a day clamp
// step, then the month walk, which takes one month step per cycle and a last
// partial-month step before done is raised.
// Throughput: one request at a time; busy stays high until done has pulsed,
// so the next request is accepted in the cycle after done at the earliest.
// Reset: rst_n asynchronously returns the controller to idle, busy low.
// Results are valid only in the done cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module date_add_days_unit
    import dad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [YEAR_W-1:0]  start_year,
    input  logic [MONTH_W-1:0] start_month,
    input  logic [DAY_W-1:0]   start_day,
    input  logic [COUNT_W-1:0] days_to_add,
    output logic               done,
    output logic [YEAR_W-1:0]  result_year,
    output logic [MONTH_W-1:0] result_month,
    output logic [DAY_W-1:0]   result_day,
    output logic               year_overflow
);

    dad_cmd_t    cmd;
    dad_status_t status;

    dad_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    dad_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .days_to_add   (days_to_add),
        .status        (status),
        .result_year   (result_year),
        .result_month  (result_month),
        .result_day    (result_day),
        .year_overflow (year_overflow)
    );

`ifndef SYNTHESIS
    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy still high after done");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result_month >= MONTH_JAN) && (result_month <= MONTH_DEC)
                 && (result_day != '0))
        else $error("result date out of range");

    a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (done && year_overflow) |-> (result_year == YEAR_MAX)
                 && (result_month == MONTH_DEC) && (result_day == DAY_LAST_DEC))
        else $error("overflow result not saturated");
`endif

endmodule
